// ===== rtl/stt_pkg.sv =====
// Package for the soft timer table: payload structs, codes and state type.
// Used by every module of the block; depends on nothing.
package stt_pkg;

  localparam int unsigned ENTRY_W = 6;
  localparam int unsigned TICK_W = 16;

  typedef enum logic [1:0] {
    KIND_ARM = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STAT_ARMED = 3'd0,
    STAT_REFUSED = 3'd1,
    STAT_CANCELLED = 3'd2,
    STAT_INVALID = 3'd3,
    STAT_FIRED = 3'd4,
    STAT_DONE = 3'd5
  } status_e;

  typedef enum logic {
    REG_MIN_DELAY = 1'b0,
    REG_MAX_DELAY = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MODW,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic has_callback;
    logic [TICK_W-1:0] delay;
    logic [TICK_W-1:0] period;
    logic [ENTRY_W-1:0] handle;
    logic [TICK_W-1:0] elapsed;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] status;
    logic [ENTRY_W-1:0] entry;
    logic reload_set;
    logic [TICK_W-1:0] reload_value;
    logic running;
    logic last;
  } out_beat_t;

endpackage

// ===== rtl/stt_mod_unit.sv =====
// Serial restoring remainder unit: one quotient bit per cycle.
// Depends on stt_pkg for the tick width.
module stt_mod_unit import stt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [TICK_W-1:0] dividend_i,
  input  logic [TICK_W-1:0] divisor_i,
  output logic done_o,
  output logic [TICK_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(TICK_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [TICK_W-1:0] dvd_q, dvd_d;
  logic [TICK_W-1:0] dvs_q, dvs_d;
  logic [TICK_W-1:0] rem_q, rem_d;
  logic [TICK_W:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    dvs_d = dvs_q;
    rem_d = rem_q;
    trial = {rem_q, dvd_q[TICK_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      rem_d = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[TICK_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = TICK_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[TICK_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(TICK_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o = rem_q;

endmodule

// ===== rtl/soft_timer_table_unit.sv =====
// Top level of the soft timer table: entry store, sequencer and result register.
// Depends on stt_pkg and stt_mod_unit.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o | in_data_i (in_beat_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (out_beat_t)
//   cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// Arm and cancel are handled in the idle state with one result beat each. A dispatch
// walks the entries one per cycle, but holds on each periodic entry that fires while
// the serial remainder unit runs, then sends one beat per fired entry and a final beat.
// Reset is asynchronous, clears the armed flags and sets the sleep time to 0xFFFF.
// A stalled result beat holds the sequencer; no input is taken until done.
module soft_timer_table_unit import stt_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_beat_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_beat_t out_data_o,
  input  logic cfg_we_i,
  input  logic cfg_idx_i,
  input  logic [TICK_W-1:0] cfg_data_i
);

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);

  state_e state_q, state_d;
  logic [TICK_W-1:0] min_q, max_q;
  logic [NUM_TIMERS-1:0] armed_q, armed_d;
  logic [NUM_TIMERS-1:0] fired_q, fired_d;
  logic [TICK_W-1:0] iv_q [NUM_TIMERS];
  logic [TICK_W:0] rem_q [NUM_TIMERS];
  logic wr_en;
  logic [IW-1:0] wr_idx;
  logic [TICK_W-1:0] wr_iv;
  logic wr_iv_en;
  logic [TICK_W:0] wr_rem;
  logic [TICK_W:0] sleep_q, sleep_d;
  logic [TICK_W+1:0] tot_q, tot_d;
  logic [TICK_W-1:0] next_q, next_d;
  logic [TICK_W-1:0] elap_q, elap_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] cur;
  out_beat_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic out_free, accept;
  logic walk_end, cur_due, emit_end;
  logic mod_start, mod_done;
  logic [TICK_W-1:0] mod_rem;
  logic slot_found;
  logic [IW-1:0] slot;
  logic [TICK_W-1:0] dl, pd;
  logic [TICK_W:0] decr;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == ST_IDLE) || !out_free;
  assign accept = in_valid_i && !in_stall_o;
  assign cur = idx_q[IW-1:0];
  assign walk_end = (idx_q == CW'(NUM_TIMERS));
  assign emit_end = walk_end;
  assign cur_due = ({1'b0, rem_q[cur]} <= tot_q);
  assign decr = TICK_W'(0) + (TICK_W+1)'({1'b0, rem_q[cur]} - tot_q);
  assign mod_start = (state_q == ST_WALK) && !walk_end && armed_q[cur] && cur_due
                     && (iv_q[cur] != '0);

  always_comb begin
    slot_found = 1'b0;
    slot = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!armed_q[i]) begin
        slot_found = 1'b1;
        slot = IW'(i);
      end
    end
    dl = (in_data_i.delay < min_q) ? min_q : in_data_i.delay;
    dl = (dl > max_q) ? max_q : dl;
    pd = (in_data_i.period != '0 && in_data_i.period < min_q) ? min_q : in_data_i.period;
  end

  stt_mod_unit u_mod (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(mod_start),
    .dividend_i(elap_q),
    .divisor_i(iv_q[cur]),
    .done_o(mod_done),
    .rem_o(mod_rem)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_data_i.kind == KIND_DISPATCH) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          state_d = ST_EMIT;
        end else if (mod_start) begin
          state_d = ST_MODW;
        end
      end
      ST_MODW: begin
        if (mod_done) begin
          state_d = ST_WALK;
        end
      end
      ST_EMIT: begin
        if (emit_end && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    armed_d = armed_q;
    fired_d = fired_q;
    sleep_d = sleep_q;
    tot_d = tot_q;
    next_d = next_q;
    elap_d = elap_q;
    idx_d = idx_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en = 1'b0;
    wr_iv_en = 1'b0;
    wr_idx = cur;
    wr_iv = pd;
    wr_rem = decr;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_d.entry = '0;
          out_d.reload_set = 1'b0;
          out_d.reload_value = '0;
          out_d.last = 1'b1;
          case (in_data_i.kind)
            KIND_ARM: begin
              out_valid_d = 1'b1;
              if (!in_data_i.has_callback || !slot_found) begin
                out_d.status = STAT_REFUSED;
              end else begin
                out_d.status = STAT_ARMED;
                out_d.entry = ENTRY_W'(slot);
                if (sleep_q > {1'b0, in_data_i.elapsed}
                    && (sleep_q - {1'b0, in_data_i.elapsed}) > {1'b0, dl}) begin
                  sleep_d = {1'b0, dl} + {1'b0, in_data_i.elapsed};
                  out_d.reload_set = 1'b1;
                  out_d.reload_value = dl;
                end
                wr_en = 1'b1;
                wr_iv_en = 1'b1;
                wr_idx = slot;
                wr_rem = {1'b0, dl} + {1'b0, in_data_i.elapsed};
                armed_d[slot] = 1'b1;
              end
            end
            KIND_CANCEL: begin
              out_valid_d = 1'b1;
              out_d.entry = in_data_i.handle;
              if (in_data_i.handle < ENTRY_W'(NUM_TIMERS)) begin
                out_d.status = STAT_CANCELLED;
                armed_d[in_data_i.handle[IW-1:0]] = 1'b0;
              end else begin
                out_d.status = STAT_INVALID;
              end
            end
            KIND_DISPATCH: begin
              tot_d = {1'b0, sleep_q} + (TICK_W+2)'(in_data_i.elapsed);
              next_d = max_q;
              elap_d = in_data_i.elapsed;
              idx_d = '0;
              fired_d = '0;
            end
            default: begin
            end
          endcase
          out_d.running = |armed_d;
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          sleep_d = {1'b0, next_q};
          idx_d = '0;
        end else if (!armed_q[cur]) begin
          idx_d = idx_q + 1'b1;
        end else if (cur_due) begin
          fired_d[cur] = 1'b1;
          if (iv_q[cur] == '0) begin
            armed_d[cur] = 1'b0;
            idx_d = idx_q + 1'b1;
          end
        end else begin
          wr_en = 1'b1;
          if (decr < {1'b0, next_q}) begin
            next_d = decr[TICK_W-1:0];
          end
          idx_d = idx_q + 1'b1;
        end
      end
      ST_MODW: begin
        if (mod_done) begin
          wr_en = 1'b1;
          wr_rem = {1'b0, iv_q[cur] - mod_rem};
          if ((iv_q[cur] - mod_rem) < next_q) begin
            next_d = iv_q[cur] - mod_rem;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_d.running = |armed_q;
          if (emit_end) begin
            out_valid_d = 1'b1;
            out_d.status = STAT_DONE;
            out_d.entry = '0;
            out_d.reload_set = 1'b1;
            out_d.reload_value = next_q;
            out_d.last = 1'b1;
          end else begin
            if (fired_q[cur]) begin
              out_valid_d = 1'b1;
              out_d.status = STAT_FIRED;
              out_d.entry = ENTRY_W'(cur);
              out_d.reload_set = 1'b0;
              out_d.reload_value = '0;
              out_d.last = 1'b0;
            end
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      armed_q <= '0;
      sleep_q <= (TICK_W+1)'(16'hFFFF);
      min_q <= TICK_W'(1);
      max_q <= 16'hFFFF;
      out_valid_q <= 1'b0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      armed_q <= armed_d;
      sleep_q <= sleep_d;
      out_valid_q <= out_valid_d;
      idx_q <= idx_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MIN_DELAY) begin
          min_q <= cfg_data_i;
        end else begin
          max_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fired_q <= fired_d;
    tot_q <= tot_d;
    next_q <= next_d;
    elap_q <= elap_d;
    out_q <= out_d;
    if (wr_en) begin
      rem_q[wr_idx] <= wr_rem;
    end
    if (wr_iv_en) begin
      iv_q[wr_idx] <= wr_iv;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  a_fired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_FIRED |-> !out_data_o.last)
    else $error("fired beat marked last");
  a_done_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_DONE |-> out_data_o.reload_set && out_data_o.last)
    else $error("dispatch done beat without reload");
  a_mod_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == ST_MODW)
    else $error("remainder finished outside wait state");
  a_dispatch_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.kind == KIND_DISPATCH |=> state_q == ST_WALK && idx_q == '0)
    else $error("dispatch did not start the walk");

endmodule

// ===== dv/stt_checker.sv =====
// Checker for the soft timer table: watches the input, output and register beats.
// Predicts every result beat from its own model of the table and compares them.
// Depends on stt_pkg.
module stt_checker import stt_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_beat_t in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_beat_t out_data_i,
  input  logic cfg_we_i,
  input  logic cfg_idx_i,
  input  logic [TICK_W-1:0] cfg_data_i,
  output int errors_o,
  output int pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] min_delay_q, max_delay_q;
  logic armed_q [NUM_TIMERS];
  logic [15:0] interval_q [NUM_TIMERS];
  logic [16:0] remaining_q [NUM_TIMERS];
  logic [16:0] sleep_q;
  out_beat_t pending_beats [$];

  assign pending_o = pending_beats.size();

  function automatic logic any_armed();
    for (int i = 0; i < NUM_TIMERS; i++) if (armed_q[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic out_beat_t mk(status_e st, int unsigned ent, logic rs,
                                   logic [15:0] rv, logic lst);
    out_beat_t b;
    b.status = st;
    b.entry = ent[5:0];
    b.reload_set = rs;
    b.reload_value = rv;
    b.running = any_armed();
    b.last = lst;
    return b;
  endfunction

  task automatic predict_timers(input in_beat_t b);
    int slot;
    logic [31:0] dly, per, total, next, iv, elap;
    logic fired [NUM_TIMERS];
    logic rs;
    logic [15:0] rv;
    slot = -1;
    rs = 1'b0;
    rv = '0;
    elap = 32'(b.elapsed);
    case (kind_e'(b.kind))
      KIND_ARM: begin
        if (b.has_callback) begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (!armed_q[i] && slot < 0) slot = i;
          end
        end
        if (slot < 0) begin
          pending_beats.push_back(mk(STAT_REFUSED, 0, 1'b0, '0, 1'b1));
        end else begin
          dly = 32'(b.delay);
          per = 32'(b.period);
          if (dly < 32'(min_delay_q)) dly = 32'(min_delay_q);
          if (dly > 32'(max_delay_q)) dly = 32'(max_delay_q);
          if (per != 0 && per < 32'(min_delay_q)) per = 32'(min_delay_q);
          if (32'(sleep_q) > elap && 32'(sleep_q) - elap > dly) begin
            sleep_q = 17'(elap + dly);
            rs = 1'b1;
            rv = dly[15:0];
          end
          remaining_q[slot] = 17'(dly + elap);
          interval_q[slot] = per[15:0];
          armed_q[slot] = 1'b1;
          pending_beats.push_back(mk(STAT_ARMED, slot, rs, rv, 1'b1));
        end
      end
      KIND_CANCEL: begin
        if (b.handle < NUM_TIMERS) begin
          armed_q[b.handle] = 1'b0;
          pending_beats.push_back(mk(STAT_CANCELLED, b.handle, 1'b0, '0, 1'b1));
        end else begin
          pending_beats.push_back(mk(STAT_INVALID, b.handle, 1'b0, '0, 1'b1));
        end
      end
      KIND_DISPATCH: begin
        total = 32'(sleep_q) + elap;
        next = 32'(max_delay_q);
        for (int i = 0; i < NUM_TIMERS; i++) begin
          fired[i] = 1'b0;
          if (armed_q[i]) begin
            if (32'(remaining_q[i]) <= total) begin
              iv = 32'(interval_q[i]);
              fired[i] = 1'b1;
              if (iv == 0) begin
                armed_q[i] = 1'b0;
              end else begin
                remaining_q[i] = 17'(iv - (elap % iv));
                if (32'(remaining_q[i]) < next) next = 32'(remaining_q[i]);
              end
            end else begin
              remaining_q[i] = 17'(32'(remaining_q[i]) - total);
              if (32'(remaining_q[i]) < next) next = 32'(remaining_q[i]);
            end
          end
        end
        sleep_q = next[16:0];
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (fired[i]) pending_beats.push_back(mk(STAT_FIRED, i, 1'b0, '0, 1'b0));
        end
        pending_beats.push_back(mk(STAT_DONE, 0, 1'b1, next[15:0], 1'b1));
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t exp_beat;
    if (!rst_ni) begin
      min_delay_q <= 16'd1;
      max_delay_q <= 16'hFFFF;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        armed_q[i] = 1'b0;
        interval_q[i] = '0;
        remaining_q[i] = '0;
      end
      sleep_q = 17'hFFFF;
      errors_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (reg_e'(cfg_idx_i) == REG_MIN_DELAY) min_delay_q <= cfg_data_i;
        else max_delay_q <= cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_beats.size() == 0) begin
          $display("%0t: mismatch expected no beat actual %p", $time, out_data_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_beat = pending_beats.pop_front();
          if (exp_beat !== out_data_i) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_beat, out_data_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_timers(in_data_i);
    end
  end
endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the soft timer table: clock, reset, stimulus and verdict.
// Depends on stt_pkg, soft_timer_table_unit and stt_checker.
module tb_top;
  import stt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_TIMERS = 16;
  localparam int unsigned IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_idx = 1'b0;
  logic [TICK_W-1:0] cfg_data = '0;
  int errors, pending, idle_cycles;
  logic stall_mode = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  soft_timer_table_unit #(.NUM_TIMERS(NUM_TIMERS)) DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  stt_checker #(.NUM_TIMERS(NUM_TIMERS)) u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  // The receiver alternates between quiet stretches and heavy stalling.
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    out_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_beat(input in_beat_t b);
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic gap_beat();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain_timers();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input reg_e idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_beat_t mk_in(kind_e k, logic cb, logic [15:0] d,
                                     logic [15:0] p, logic [5:0] h, logic [15:0] e);
    in_beat_t b;
    b.kind = k;
    b.has_callback = cb;
    b.delay = d;
    b.period = p;
    b.handle = h;
    b.elapsed = e;
    return b;
  endfunction

  function automatic in_beat_t rand_timer_beat();
    in_beat_t b;
    int unsigned r;
    b = in_beat_t'($bits(in_beat_t)'({$urandom, $urandom}));
    r = $urandom_range(0, 99);
    if (r < 45) begin
      b.kind = KIND_ARM;
      b.has_callback = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 3) != 0) b.delay = 16'($urandom_range(0, 300));
      if ($urandom_range(0, 2) == 0) b.period = '0;
      else if ($urandom_range(0, 1)) b.period = 16'($urandom_range(1, 200));
      if ($urandom_range(0, 1)) b.elapsed = 16'($urandom_range(0, 100));
    end else if (r < 65) begin
      b.kind = KIND_CANCEL;
      if ($urandom_range(0, 4) != 0) b.handle = 6'($urandom_range(0, NUM_TIMERS - 1));
    end else if (r < 97) begin
      b.kind = KIND_DISPATCH;
      if ($urandom_range(0, 2) != 0) b.elapsed = 16'($urandom_range(0, 400));
    end else begin
      b.kind = KIND_NONE;
    end
    return b;
  endfunction

  initial begin
    int unsigned burst;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    send_beat(mk_in(KIND_DISPATCH, 1'b0, 16'd0, 16'd0, 6'd0, 16'd0));
    send_beat(mk_in(KIND_ARM, 1'b0, 16'd10, 16'd0, 6'd0, 16'd0));
    send_beat(mk_in(KIND_ARM, 1'b1, 16'd0, 16'd0, 6'd0, 16'd0));
    send_beat(mk_in(KIND_ARM, 1'b1, 16'hFFFF, 16'hFFFF, 6'd0, 16'hFFFF));
    send_beat(mk_in(KIND_ARM, 1'b1, 16'd5, 16'd1, 6'd0, 16'd3));
    send_beat(mk_in(KIND_CANCEL, 1'b0, 16'd0, 16'd0, 6'd63, 16'd0));
    send_beat(mk_in(KIND_CANCEL, 1'b0, 16'd0, 16'd0, 6'd16, 16'd0));
    send_beat(mk_in(KIND_CANCEL, 1'b0, 16'd0, 16'd0, 6'd9, 16'd0));
    send_beat(mk_in(KIND_NONE, 1'b1, 16'hFFFF, 16'hFFFF, 6'd63, 16'hFFFF));
    send_beat(mk_in(KIND_DISPATCH, 1'b0, 16'd0, 16'd0, 6'd0, 16'd10));
    send_beat(mk_in(KIND_DISPATCH, 1'b0, 16'd0, 16'd0, 6'd0, 16'hFFFF));
    for (int i = 0; i < NUM_TIMERS + 1; i++)
      send_beat(mk_in(KIND_ARM, 1'b1, 16'(i + 2), 16'(i % 3), 6'd0, 16'd0));
    send_beat(mk_in(KIND_DISPATCH, 1'b0, 16'd0, 16'd0, 6'd0, 16'd50));
    for (int i = 0; i < NUM_TIMERS; i++)
      send_beat(mk_in(KIND_CANCEL, 1'b0, 16'd0, 16'd0, 6'(i), 16'd0));
    drain_timers();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(REG_MIN_DELAY, 16'd20); write_reg(REG_MAX_DELAY, 16'd500); end
        1: begin write_reg(REG_MIN_DELAY, 16'd400); write_reg(REG_MAX_DELAY, 16'd100); end
        2: begin write_reg(REG_MIN_DELAY, 16'hFFFF); write_reg(REG_MAX_DELAY, 16'hFFFF); end
        default: begin write_reg(REG_MIN_DELAY, 16'd1); write_reg(REG_MAX_DELAY, 16'd1); end
      endcase
      for (int n = 0; n < 54;) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst && n < 54; k++, n++) send_beat(rand_timer_beat());
        if ($urandom_range(0, 1)) gap_beat();
      end
      drain_timers();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/stt_pkg.sv
rtl/stt_mod_unit.sv
rtl/soft_timer_table_unit.sv
dv/stt_checker.sv
dv/tb_top.sv
